FILE: rtl/sgm_pkg.sv
`timescale 1ns / 1ps

package sgm_pkg;

    // default sizing
    localparam int MAX_DISP_DEFAULT   = 128;
    localparam int COST_WIDTH_DEFAULT = 11;

    // field widths
    localparam int DISP_W    = 7;
    localparam int MATCH_W   = 8;
    localparam int INTEN_W   = 8;
    localparam int OUT_W     = 11;
    localparam int P1_W      = 8;
    localparam int P2_W      = 10;
    localparam int ODIV_W    = 5;
    localparam int COUNT_W   = 8;
    localparam int DIVISOR_W = 9;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_PENALTY   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LARGE_PENALTY   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_DIVISOR  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPARITY_COUNT = 2'd3;

    // register reset values
    localparam logic [P1_W-1:0]    SMALL_PENALTY_RST   = 8'd10;
    localparam logic [P2_W-1:0]    LARGE_PENALTY_RST   = 10'd150;
    localparam logic [ODIV_W-1:0]  OUTPUT_DIVISOR_RST  = 5'd4;
    localparam logic [COUNT_W-1:0] DISPARITY_COUNT_RST = 8'd64;

endpackage

FILE: rtl/sgm_path_cost_aggregator_core.sv
`timescale 1ns / 1ps

// Path cost aggregation for semi-global matching along one scan path.
// s_ channel: one matching cost per transaction, the disparities of a pixel in
// increasing order, pixel after pixel; s_path_start marks every transaction of
// the first pixel of a path. m_ channel: one result per input transaction
// (path cost, cost divided by output_divisor, disparity, last-disparity flag).
// cfg channel: register writes by index (0 small_penalty, 1 large_penalty,
// 2 output_divisor, 3 disparity_count), always ready; the user must write only
// while idle, as the block does not enforce it. One transaction is in work at
// a time. A transaction within the disparity count and not on a path start
// goes through the large penalty division (11 shift-subtract steps and a done
// strobe), three reads of the previous pixel's cost bank (one read port,
// registered read data), the cost step, the write-back, the contribution
// division and the load into the output register. Path-start or out-of-range
// transactions skip the penalty division and the reads. s_ready returns the
// cycle after the result loads. The divider takes one step per quotient bit.
// A finished result waits in the output register while the next transaction
// is accepted; a stalled receiver holds the block once the next result is ready.

module sgm_path_cost_aggregator_core #(
    parameter int MAX_DISPARITIES = sgm_pkg::MAX_DISP_DEFAULT,
    parameter int COST_WIDTH      = sgm_pkg::COST_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sgm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_path_start,
    input  logic [sgm_pkg::DISP_W-1:0]       s_disparity,
    input  logic [sgm_pkg::MATCH_W-1:0]      s_match_cost,
    input  logic [sgm_pkg::INTEN_W-1:0]      s_intensity,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sgm_pkg::OUT_W-1:0]        m_path_cost,
    output logic [sgm_pkg::OUT_W-1:0]        m_contribution,
    output logic [sgm_pkg::DISP_W-1:0]       m_disparity_out,
    output logic                             m_pixel_done
);

    localparam int DEPTH = 2 * MAX_DISPARITIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = (COST_WIDTH > sgm_pkg::P2_W) ? COST_WIDTH : sgm_pkg::P2_W;
    localparam int BW    = QW + 1;
    localparam int SW    = BW + 1;
    localparam int NW    = $clog2(MAX_DISPARITIES + 1);
    localparam int EW    = ((NW > sgm_pkg::DISP_W) ? NW : sgm_pkg::DISP_W) + 1;
    localparam int XW    = ((AW > EW) ? AW : EW) + 1;
    localparam int DVW   = sgm_pkg::DIVISOR_W;

    localparam logic [COST_WIDTH-1:0] COST_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P2,
        ST_RD_MID,
        ST_RD_LO,
        ST_RD_HI,
        ST_COST,
        ST_WB,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [sgm_pkg::P1_W-1:0]    small_penalty_reg;
    logic [sgm_pkg::P2_W-1:0]    large_penalty_reg;
    logic [sgm_pkg::ODIV_W-1:0]  output_divisor_reg;
    logic [sgm_pkg::COUNT_W-1:0] disparity_count_reg;

    // path state
    logic                         bank_sel_reg;
    logic [COST_WIDTH-1:0]        prev_min_reg;
    logic [COST_WIDTH-1:0]        run_min_reg;
    logic [sgm_pkg::INTEN_W-1:0]  prev_inten_reg;

    // transaction in work
    logic                         start_reg;
    logic                         in_range_reg;
    logic                         last_reg;
    logic [sgm_pkg::DISP_W-1:0]   disp_reg;
    logic [sgm_pkg::MATCH_W-1:0]  match_reg;
    logic [sgm_pkg::INTEN_W-1:0]  inten_reg;
    logic [BW-1:0]                best_reg;
    logic [COST_WIDTH-1:0]        cost_reg;

    // output register
    logic                         m_valid_reg;
    logic [sgm_pkg::OUT_W-1:0]    m_path_cost_reg;
    logic [sgm_pkg::OUT_W-1:0]    m_contribution_reg;
    logic [sgm_pkg::DISP_W-1:0]   m_disparity_reg;
    logic                         m_pixel_done_reg;

    // combinational
    logic [EW-1:0]                cnt_eff;
    logic [EW-1:0]                s_disp_ext;
    logic                         s_in_range;
    logic                         s_last;
    logic [sgm_pkg::INTEN_W-1:0]  inten_diff;
    logic [EW-1:0]                disp_ext;
    logic [XW-1:0]                prv_base;
    logic [XW-1:0]                cur_base;
    logic [XW-1:0]                addr_mid;
    logic [XW-1:0]                addr_lo;
    logic [XW-1:0]                addr_hi;
    logic [XW-1:0]                addr_wr;
    logic [sgm_pkg::P2_W-1:0]     p2_next;
    logic [BW-1:0]                cand;
    logic [BW-1:0]                best_next;
    logic [SW-1:0]                sum_total;
    logic [SW-1:0]                sum_diff;
    logic [COST_WIDTH-1:0]        cost_next;
    logic [COST_WIDTH-1:0]        run_min_next;
    logic [sgm_pkg::ODIV_W-1:0]   odiv_eff;
    logic                         accept;
    logic                         out_load;

    logic                         mem_wr_en;
    logic                         mem_rd_en;
    logic [AW-1:0]                mem_rd_addr;
    logic [COST_WIDTH-1:0]        mem_rd_data;

    logic                         div_start;
    logic [QW-1:0]                div_dividend;
    logic [DVW-1:0]               div_divisor;
    logic                         div_busy;
    logic                         div_done;
    logic [QW-1:0]                div_quot;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        if (disparity_count_reg == '0) begin
            cnt_eff = EW'(1);
        end else if (EW'(disparity_count_reg) > EW'(MAX_DISPARITIES)) begin
            cnt_eff = EW'(MAX_DISPARITIES);
        end else begin
            cnt_eff = EW'(disparity_count_reg);
        end
    end

    assign s_disp_ext = EW'(s_disparity);
    assign s_in_range = (s_disp_ext < cnt_eff);
    assign s_last     = ((s_disp_ext + 1'b1) == cnt_eff);
    assign inten_diff = (s_intensity > prev_inten_reg) ? (s_intensity - prev_inten_reg)
                                                       : (prev_inten_reg - s_intensity);
    assign odiv_eff   = (output_divisor_reg == '0) ? sgm_pkg::ODIV_W'(1) : output_divisor_reg;

    // bank addressing: previous pixel is read, current pixel is written
    assign disp_ext = EW'(disp_reg);
    assign prv_base = bank_sel_reg ? XW'(0) : XW'(MAX_DISPARITIES);
    assign cur_base = bank_sel_reg ? XW'(MAX_DISPARITIES) : XW'(0);
    assign addr_mid = prv_base + XW'(disp_ext);
    assign addr_lo  = addr_mid - 1'b1;
    assign addr_hi  = addr_mid + 1'b1;
    assign addr_wr  = cur_base + XW'(disp_ext);

    assign mem_wr_en = (state_reg == ST_WB) && in_range_reg;

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_mid[AW-1:0];
        case (state_reg)
            ST_P2: begin
                mem_rd_en   = div_done;
                mem_rd_addr = addr_mid[AW-1:0];
            end
            ST_RD_MID: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_lo[AW-1:0];
            end
            ST_RD_LO: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_hi[AW-1:0];
            end
            default: begin
                mem_rd_en   = 1'b0;
            end
        endcase
    end

    // shared divider: large penalty over intensity step, then the contribution
    always_comb begin
        div_start    = 1'b0;
        div_dividend = QW'(large_penalty_reg);
        div_divisor  = DVW'(inten_diff) + 1'b1;
        if (state_reg == ST_IDLE) begin
            div_start = s_valid && s_in_range && !s_path_start;
        end else if (state_reg == ST_WB) begin
            div_start    = 1'b1;
            div_dividend = QW'(cost_reg);
            div_divisor  = DVW'(odiv_eff);
        end
    end

    always_comb begin
        p2_next = div_quot[sgm_pkg::P2_W-1:0];
        if (p2_next < sgm_pkg::P2_W'(small_penalty_reg)) begin
            p2_next = sgm_pkg::P2_W'(small_penalty_reg);
        end
    end

    // neighbor candidates fold into the running best one read at a time
    always_comb begin
        cand      = BW'(mem_rd_data) + BW'(small_penalty_reg);
        best_next = best_reg;
        case (state_reg)
            ST_RD_MID: begin
                if (BW'(mem_rd_data) < best_reg) begin
                    best_next = BW'(mem_rd_data);
                end
            end
            ST_RD_LO: begin
                if (disp_reg != '0 && cand < best_reg) begin
                    best_next = cand;
                end
            end
            ST_RD_HI: begin
                if ((disp_ext + 1'b1) < cnt_eff && cand < best_reg) begin
                    best_next = cand;
                end
            end
            default: begin
                best_next = best_reg;
            end
        endcase
    end

    always_comb begin
        sum_total = SW'(match_reg) + SW'(best_reg);
        sum_diff  = sum_total - SW'(prev_min_reg);
        if (start_reg || !in_range_reg) begin
            cost_next = COST_WIDTH'(match_reg);
        end else if (sum_total < SW'(prev_min_reg)) begin
            cost_next = '0;
        end else if (sum_diff > SW'(COST_MAX)) begin
            cost_next = COST_MAX;
        end else begin
            cost_next = sum_diff[COST_WIDTH-1:0];
        end
    end

    assign run_min_next = (cost_reg < run_min_reg) ? cost_reg : run_min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_penalty_reg   <= sgm_pkg::SMALL_PENALTY_RST;
            large_penalty_reg   <= sgm_pkg::LARGE_PENALTY_RST;
            output_divisor_reg  <= sgm_pkg::OUTPUT_DIVISOR_RST;
            disparity_count_reg <= sgm_pkg::DISPARITY_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sgm_pkg::CFG_SMALL_PENALTY: begin
                    small_penalty_reg <= cfg_data[sgm_pkg::P1_W-1:0];
                end
                sgm_pkg::CFG_LARGE_PENALTY: begin
                    large_penalty_reg <= cfg_data[sgm_pkg::P2_W-1:0];
                end
                sgm_pkg::CFG_OUTPUT_DIVISOR: begin
                    output_divisor_reg <= cfg_data[sgm_pkg::ODIV_W-1:0];
                end
                sgm_pkg::CFG_DISPARITY_COUNT: begin
                    disparity_count_reg <= cfg_data[sgm_pkg::COUNT_W-1:0];
                end
                default: begin
                    small_penalty_reg <= small_penalty_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bank_sel_reg   <= 1'b0;
            prev_min_reg   <= '0;
            run_min_reg    <= COST_MAX;
            prev_inten_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        start_reg    <= s_path_start;
                        in_range_reg <= s_in_range;
                        last_reg     <= s_last;
                        disp_reg     <= s_disparity;
                        match_reg    <= s_match_cost;
                        inten_reg    <= s_intensity;
                        state_reg    <= (s_in_range && !s_path_start) ? ST_P2 : ST_COST;
                    end
                end
                ST_P2: begin
                    if (div_done) begin
                        best_reg  <= BW'(prev_min_reg) + BW'(p2_next);
                        state_reg <= ST_RD_MID;
                    end
                end
                ST_RD_MID: begin
                    best_reg  <= best_next;
                    state_reg <= ST_RD_LO;
                end
                ST_RD_LO: begin
                    best_reg  <= best_next;
                    state_reg <= ST_RD_HI;
                end
                ST_RD_HI: begin
                    best_reg  <= best_next;
                    state_reg <= ST_COST;
                end
                ST_COST: begin
                    cost_reg  <= cost_next;
                    state_reg <= ST_WB;
                end
                ST_WB: begin
                    if (in_range_reg) begin
                        if (last_reg) begin
                            prev_min_reg   <= run_min_next;
                            run_min_reg    <= COST_MAX;
                            prev_inten_reg <= inten_reg;
                            bank_sel_reg   <= !bank_sel_reg;
                        end else begin
                            run_min_reg <= run_min_next;
                        end
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_valid_reg        <= 1'b1;
                        m_path_cost_reg    <= sgm_pkg::OUT_W'(cost_reg);
                        m_contribution_reg <= sgm_pkg::OUT_W'(div_quot);
                        m_disparity_reg    <= disp_reg;
                        m_pixel_done_reg   <= in_range_reg && last_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_path_cost     = m_path_cost_reg;
    assign m_contribution  = m_contribution_reg;
    assign m_disparity_out = m_disparity_reg;
    assign m_pixel_done    = m_pixel_done_reg;

    sgm_cost_ram #(
        .DEPTH (DEPTH),
        .WIDTH (COST_WIDTH),
        .AW    (AW)
    ) u_cost_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (addr_wr[AW-1:0]),
        .wr_data (cost_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    sgm_divider #(
        .QW (QW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

`ifndef SYNTH
    // a cost bank write only for disparities inside the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> in_range_reg)
        else $error("cost bank write outside disparity count");

    // the shared divider is never restarted while busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // one transaction in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction is in work");

    // bank select moves only at the end of a pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(bank_sel_reg)) |->
            $past(state_reg == ST_WB && in_range_reg && last_reg))
        else $error("bank select toggled outside pixel end");

    // result register never overwritten while still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

FILE: rtl/sgm_cost_ram.sv
`timescale 1ns / 1ps

module sgm_cost_ram #(
    parameter int DEPTH = 2 * sgm_pkg::MAX_DISP_DEFAULT,
    parameter int WIDTH = sgm_pkg::COST_WIDTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sgm_divider.sv
`timescale 1ns / 1ps

module sgm_divider #(
    parameter int QW = sgm_pkg::COST_WIDTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [QW-1:0]                  dividend,
    input  logic [sgm_pkg::DIVISOR_W-1:0]  divisor,
    output logic                           busy,
    output logic                           done,
    output logic [QW-1:0]                  quotient
);

    localparam int DVW = sgm_pkg::DIVISOR_W;
    localparam int CNW = $clog2(QW + 1);

    logic [QW-1:0]  quot_reg;
    logic [DVW-1:0] rem_reg;
    logic [DVW-1:0] divisor_reg;
    logic [CNW-1:0] count_reg;
    logic           done_reg;

    logic [DVW:0]   trial;
    logic           fits;
    logic [DVW:0]   rem_next;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, quot_reg[QW-1]};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? (trial - {1'b0, divisor_reg}) : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else if (start) begin
            count_reg   <= CNW'(QW);
            done_reg    <= 1'b0;
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (count_reg != '0) begin
            count_reg <= count_reg - 1'b1;
            done_reg  <= (count_reg == CNW'(1));
            quot_reg  <= {quot_reg[QW-2:0], fits};
            rem_reg   <= rem_next[DVW-1:0];
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign busy     = (count_reg != '0);
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
